// File: rtl/rect_pixel_format_converter_unit_macros.svh
// Assertion macros for the converter's checker file.
`ifndef RECT_PIXEL_FORMAT_CONVERTER_UNIT_MACROS_SVH
`define RECT_PIXEL_FORMAT_CONVERTER_UNIT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define RPFC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define RPFC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/rpfc_pkg.sv
// Package with the types, codes and constants of the rectangle pixel format converter.
package rpfc_pkg;

   // Largest frame size that the converter handles.
   localparam logic [12:0] MAX_WIDTH  = 13'd4096;
   localparam logic [12:0] MAX_HEIGHT = 13'd4096;

   // Fixed pixel values.
   localparam logic [31:0] PIXEL_UNKNOWN = 32'hffff00ff;
   localparam logic [7:0]  ALPHA_OPAQUE  = 8'hff;

   // Request commands.
   typedef enum logic [1:0] {
      CMD_RECT   = 2'd0,
      CMD_PIXEL  = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_IGNORE = 2'd3
   } cmd_type;

   // Source pixel formats; codes above the last one are unknown formats.
   typedef enum logic [2:0] {
      FMT_X8R8G8B8 = 3'd0,
      FMT_R8G8B8X8 = 3'd1,
      FMT_B8G8R8X8 = 3'd2,
      FMT_R5G6B5   = 3'd3,
      FMT_X1R5G5B5 = 3'd4
   } fmt_type;

   // Register indexes of the control port.
   typedef enum logic [1:0] {
      REG_FRAME_WIDTH     = 2'd0,
      REG_FRAME_HEIGHT    = 2'd1,
      REG_SOURCE_FORMAT   = 2'd2,
      REG_SURFACE_PRESENT = 2'd3
   } reg_index_type;

   // Current configuration.
   typedef struct packed {
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [2:0]  source_format;
      logic        surface_present;
   } cfg_type;

   // Outcome of clipping a rectangle against the frame.
   typedef struct packed {
      logic        keep;
      logic [12:0] frame_w;
      logic [12:0] x;
      logic [12:0] y;
      logic [12:0] w;
      logic [12:0] h;
      logic [12:0] bottom;
   } clip_result_type;

endpackage

// File: rtl/rpfc_csr.sv
// Configuration register file of the converter.
module rpfc_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [12:0]      csr_wdata,
   output rpfc_pkg::cfg_type cfg
);

   rpfc_pkg::cfg_type cfg_ff;
   rpfc_pkg::cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Select the register that a write updates.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (rpfc_pkg::reg_index_type'(csr_index))
            rpfc_pkg::REG_FRAME_WIDTH:     cfg_in.frame_width     = csr_wdata;
            rpfc_pkg::REG_FRAME_HEIGHT:    cfg_in.frame_height    = csr_wdata;
            rpfc_pkg::REG_SOURCE_FORMAT:   cfg_in.source_format   = csr_wdata[2:0];
            rpfc_pkg::REG_SURFACE_PRESENT: cfg_in.surface_present = csr_wdata[0];
         endcase
      end
   end

   // Register state; everything comes out of reset as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/rpfc_clip.sv
// Clips a requested rectangle against the frame and decides whether it is kept.
module rpfc_clip (
   input  rpfc_pkg::cfg_type         cfg,
   input  logic signed [13:0]        rect_x,
   input  logic signed [13:0]        rect_y,
   input  logic signed [13:0]        rect_w,
   input  logic signed [13:0]        rect_h,
   output rpfc_pkg::clip_result_type clip
);

   logic [12:0]        frame_w;
   logic [12:0]        frame_h;
   logic [12:0]        x_clamped;
   logic [12:0]        y_clamped;
   logic signed [15:0] x_ext;
   logic signed [15:0] y_ext;
   logic signed [15:0] w_ext;
   logic signed [15:0] h_ext;
   logic signed [15:0] fw_ext;
   logic signed [15:0] fh_ext;
   logic signed [15:0] w_cut;
   logic signed [15:0] h_cut;

   // Saturate the frame size to the largest supported frame.
   assign frame_w = (cfg.frame_width  > rpfc_pkg::MAX_WIDTH)  ? rpfc_pkg::MAX_WIDTH
                                                              : cfg.frame_width;
   assign frame_h = (cfg.frame_height > rpfc_pkg::MAX_HEIGHT) ? rpfc_pkg::MAX_HEIGHT
                                                              : cfg.frame_height;

   // A negative origin moves to zero while the size is kept.
   assign x_clamped = rect_x[13] ? 13'd0 : rect_x[12:0];
   assign y_clamped = rect_y[13] ? 13'd0 : rect_y[12:0];

   assign x_ext  = signed'({3'b000, x_clamped});
   assign y_ext  = signed'({3'b000, y_clamped});
   assign w_ext  = 16'(rect_w);
   assign h_ext  = 16'(rect_h);
   assign fw_ext = signed'({3'b000, frame_w});
   assign fh_ext = signed'({3'b000, frame_h});

   // Cut the size at the right and bottom frame edges.
   assign w_cut = (x_ext + w_ext > fw_ext) ? fw_ext - x_ext : w_ext;
   assign h_cut = (y_ext + h_ext > fh_ext) ? fh_ext - y_ext : h_ext;

   // Keep only a non-empty rectangle on an attached, non-empty frame.
   always_comb begin
      clip.keep    = cfg.surface_present && (frame_w != 13'd0) && (frame_h != 13'd0)
                     && (w_cut > 16'sd0) && (h_cut > 16'sd0);
      clip.frame_w = frame_w;
      clip.x       = x_clamped;
      clip.y       = y_clamped;
      clip.w       = w_cut[12:0];
      clip.h       = h_cut[12:0];
      clip.bottom  = y_clamped + h_cut[12:0];
   end

endmodule

// File: rtl/rpfc_convert.sv
// Converts one source pixel word to 0xAARRGGBB.
module rpfc_convert (
   input  logic [2:0]  source_format,
   input  logic [31:0] src_pixel,
   output logic [31:0] pixel_out
);

   // Expand each known format with bit replication or byte moves; an unknown format gives PIXEL_UNKNOWN.
   always_comb begin
      unique case (source_format)
         rpfc_pkg::FMT_X8R8G8B8: begin
            pixel_out = src_pixel;
         end
         rpfc_pkg::FMT_R8G8B8X8: begin
            pixel_out = {8'h00, src_pixel[31:8]};
         end
         rpfc_pkg::FMT_B8G8R8X8: begin
            pixel_out = {rpfc_pkg::ALPHA_OPAQUE, src_pixel[15:8], src_pixel[23:16],
                         src_pixel[31:24]};
         end
         rpfc_pkg::FMT_R5G6B5: begin
            pixel_out = {rpfc_pkg::ALPHA_OPAQUE,
                         src_pixel[15:11], src_pixel[15:13],
                         src_pixel[10:5],  src_pixel[10:9],
                         src_pixel[4:0],   src_pixel[4:2]};
         end
         rpfc_pkg::FMT_X1R5G5B5: begin
            pixel_out = {rpfc_pkg::ALPHA_OPAQUE,
                         src_pixel[14:10], src_pixel[14:12],
                         src_pixel[9:5],   src_pixel[9:7],
                         src_pixel[4:0],   src_pixel[4:2]};
         end
         default: begin
            pixel_out = rpfc_pkg::PIXEL_UNKNOWN;
         end
      endcase
   end

endmodule

// File: rtl/rect_pixel_format_converter_unit.sv
// Path: a request is held in the request register and then in the response register,
// which drives the response ports.
// Throughput: one request per cycle unless the response is stalled; the row index
// multiply and the clip adders sit between the request and response registers.
// Back pressure: the response register holds while rsp_stall is high, the request
// register fills behind it, and req_stall rises only when both are full.
// Reset (synchronous, active high) clears the valid flags, the open rectangle, the dirty
// span and the update counter; no clearing pass is needed.
module rect_pixel_format_converter_unit (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [13:0] req_rect_x,
   input  logic signed [13:0] req_rect_y,
   input  logic signed [13:0] req_rect_w,
   input  logic signed [13:0] req_rect_h,
   input  logic [31:0]        req_src_pixel,
   // Response channel.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_accepted,
   output logic [23:0]        rsp_dest_index,
   output logic [31:0]        rsp_pixel_out,
   output logic [12:0]        rsp_clip_x,
   output logic [12:0]        rsp_clip_y,
   output logic [12:0]        rsp_clip_w,
   output logic [12:0]        rsp_clip_h,
   output logic               rsp_rect_done,
   output logic               rsp_dirty_flag,
   output logic [12:0]        rsp_dirty_top,
   output logic [12:0]        rsp_dirty_bottom,
   output logic [31:0]        rsp_update_count,
   // Control register port.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [12:0]        csr_wdata
);

   rpfc_pkg::cfg_type         cfg;
   rpfc_pkg::clip_result_type clip;

   // Request register.
   logic               req_valid_ff;
   logic [1:0]         req_cmd_ff;
   logic signed [13:0] req_rect_x_ff;
   logic signed [13:0] req_rect_y_ff;
   logic signed [13:0] req_rect_w_ff;
   logic signed [13:0] req_rect_h_ff;
   logic [31:0]        req_src_pixel_ff;

   // Rectangle walk and dirty tracking state.
   logic        rect_open_ff, rect_open_in;
   logic [12:0] cur_row_ff, cur_row_in;
   logic [12:0] cur_col_ff, cur_col_in;
   logic [12:0] box_x_ff, box_x_in;
   logic [12:0] box_y_ff, box_y_in;
   logic [12:0] box_w_ff, box_w_in;
   logic [12:0] box_h_ff, box_h_in;
   logic        dirty_mark_ff, dirty_mark_in;
   logic [12:0] dirty_lo_ff, dirty_lo_in;
   logic [12:0] dirty_hi_ff, dirty_hi_in;
   logic [31:0] update_counter_ff, update_counter_in;

   // Response register.
   logic        rsp_valid_ff;
   logic        rsp_accepted_ff, rsp_accepted_in;
   logic [23:0] rsp_dest_index_ff, rsp_dest_index_in;
   logic [31:0] rsp_pixel_out_ff, rsp_pixel_out_in;
   logic [12:0] rsp_clip_x_ff, rsp_clip_x_in;
   logic [12:0] rsp_clip_y_ff, rsp_clip_y_in;
   logic [12:0] rsp_clip_w_ff, rsp_clip_w_in;
   logic [12:0] rsp_clip_h_ff, rsp_clip_h_in;
   logic        rsp_rect_done_ff, rsp_rect_done_in;

   logic        out_free;
   logic        advance;
   logic [31:0] converted;
   logic [25:0] row_base;
   logic [23:0] pixel_index;
   logic [13:0] col_next;
   logic [13:0] col_end;
   logic [13:0] row_next;
   logic [13:0] row_end;

   rpfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rpfc_clip u_clip (
      .cfg    (cfg),
      .rect_x (req_rect_x_ff),
      .rect_y (req_rect_y_ff),
      .rect_w (req_rect_w_ff),
      .rect_h (req_rect_h_ff),
      .clip   (clip)
   );

   rpfc_convert u_convert (
      .source_format (cfg.source_format),
      .src_pixel     (req_src_pixel_ff),
      .pixel_out     (converted)
   );

   // Handshake: the response register frees when empty or taken, the request
   // register moves whenever the response register is free.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;

   // Destination index of the current pixel and the next walk position.
   assign row_base    = cur_row_ff * clip.frame_w;
   assign pixel_index = row_base[23:0] + {11'd0, cur_col_ff};
   assign col_next    = {1'b0, cur_col_ff} + 14'd1;
   assign col_end     = {1'b0, box_x_ff} + {1'b0, box_w_ff};
   assign row_next    = {1'b0, cur_row_ff} + 14'd1;
   assign row_end     = {1'b0, box_y_ff} + {1'b0, box_h_ff};

   // Execute the request held in the request register.
   always_comb begin
      rect_open_in      = rect_open_ff;
      cur_row_in        = cur_row_ff;
      cur_col_in        = cur_col_ff;
      box_x_in          = box_x_ff;
      box_y_in          = box_y_ff;
      box_w_in          = box_w_ff;
      box_h_in          = box_h_ff;
      dirty_mark_in     = dirty_mark_ff;
      dirty_lo_in       = dirty_lo_ff;
      dirty_hi_in       = dirty_hi_ff;
      update_counter_in = update_counter_ff;
      rsp_accepted_in   = 1'b0;
      rsp_dest_index_in = 24'd0;
      rsp_pixel_out_in  = 32'd0;
      rsp_clip_x_in     = 13'd0;
      rsp_clip_y_in     = 13'd0;
      rsp_clip_w_in     = 13'd0;
      rsp_clip_h_in     = 13'd0;
      rsp_rect_done_in  = 1'b0;
      if (advance) begin
         unique case (rpfc_pkg::cmd_type'(req_cmd_ff))
            rpfc_pkg::CMD_RECT: begin
               // A new rectangle always closes the old one; a kept one opens.
               rect_open_in = 1'b0;
               if (clip.keep) begin
                  rect_open_in      = 1'b1;
                  box_x_in          = clip.x;
                  box_y_in          = clip.y;
                  box_w_in          = clip.w;
                  box_h_in          = clip.h;
                  cur_col_in        = clip.x;
                  cur_row_in        = clip.y;
                  dirty_mark_in     = 1'b1;
                  update_counter_in = update_counter_ff + 32'd1;
                  if (!dirty_mark_ff) begin
                     dirty_lo_in = clip.y;
                     dirty_hi_in = clip.bottom;
                  end else begin
                     if (clip.y < dirty_lo_ff) begin
                        dirty_lo_in = clip.y;
                     end
                     if (clip.bottom > dirty_hi_ff) begin
                        dirty_hi_in = clip.bottom;
                     end
                  end
                  rsp_accepted_in = 1'b1;
                  rsp_clip_x_in   = clip.x;
                  rsp_clip_y_in   = clip.y;
                  rsp_clip_w_in   = clip.w;
                  rsp_clip_h_in   = clip.h;
               end
            end
            rpfc_pkg::CMD_PIXEL: begin
               // While a rectangle is open, convert and place one pixel, then step in row-major order.
               if (rect_open_ff) begin
                  rsp_accepted_in   = 1'b1;
                  rsp_dest_index_in = pixel_index;
                  rsp_pixel_out_in  = converted;
                  rsp_clip_x_in     = box_x_ff;
                  rsp_clip_y_in     = box_y_ff;
                  rsp_clip_w_in     = box_w_ff;
                  rsp_clip_h_in     = box_h_ff;
                  if (col_next >= col_end) begin
                     cur_col_in = box_x_ff;
                     cur_row_in = row_next[12:0];
                     if (row_next >= row_end) begin
                        rsp_rect_done_in = 1'b1;
                        rect_open_in     = 1'b0;
                     end
                  end else begin
                     cur_col_in = col_next[12:0];
                  end
               end
            end
            rpfc_pkg::CMD_CLEAR: begin
               // Empty the dirty span and the counter; an open rectangle stays.
               dirty_mark_in     = 1'b0;
               dirty_lo_in       = 13'd0;
               dirty_hi_in       = 13'd0;
               update_counter_in = 32'd0;
            end
            rpfc_pkg::CMD_IGNORE: begin
               // No state change; the response carries only the dirty state.
               rect_open_in = rect_open_ff;
            end
         endcase
      end
   end

   // Request register: loads whenever it is not stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         req_cmd_ff       <= req_cmd;
         req_rect_x_ff    <= req_rect_x;
         req_rect_y_ff    <= req_rect_y;
         req_rect_w_ff    <= req_rect_w;
         req_rect_h_ff    <= req_rect_h;
         req_src_pixel_ff <= req_src_pixel;
      end
   end

   // Walk and dirty state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rect_open_ff      <= 1'b0;
         cur_row_ff        <= 13'd0;
         cur_col_ff        <= 13'd0;
         box_x_ff          <= 13'd0;
         box_y_ff          <= 13'd0;
         box_w_ff          <= 13'd0;
         box_h_ff          <= 13'd0;
         dirty_mark_ff     <= 1'b0;
         dirty_lo_ff       <= 13'd0;
         dirty_hi_ff       <= 13'd0;
         update_counter_ff <= 32'd0;
      end else begin
         rect_open_ff      <= rect_open_in;
         cur_row_ff        <= cur_row_in;
         cur_col_ff        <= cur_col_in;
         box_x_ff          <= box_x_in;
         box_y_ff          <= box_y_in;
         box_w_ff          <= box_w_in;
         box_h_ff          <= box_h_in;
         dirty_mark_ff     <= dirty_mark_in;
         dirty_lo_ff       <= dirty_lo_in;
         dirty_hi_ff       <= dirty_hi_in;
         update_counter_ff <= update_counter_in;
      end
   end

   // Response register: dirty fields show the state after the request.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_accepted_ff   <= rsp_accepted_in;
         rsp_dest_index_ff <= rsp_dest_index_in;
         rsp_pixel_out_ff  <= rsp_pixel_out_in;
         rsp_clip_x_ff     <= rsp_clip_x_in;
         rsp_clip_y_ff     <= rsp_clip_y_in;
         rsp_clip_w_ff     <= rsp_clip_w_in;
         rsp_clip_h_ff     <= rsp_clip_h_in;
         rsp_rect_done_ff  <= rsp_rect_done_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_dest_index   = rsp_dest_index_ff;
   assign rsp_pixel_out    = rsp_pixel_out_ff;
   assign rsp_clip_x       = rsp_clip_x_ff;
   assign rsp_clip_y       = rsp_clip_y_ff;
   assign rsp_clip_w       = rsp_clip_w_ff;
   assign rsp_clip_h       = rsp_clip_h_ff;
   assign rsp_rect_done    = rsp_rect_done_ff;
   assign rsp_dirty_flag   = dirty_mark_ff;
   assign rsp_dirty_top    = dirty_lo_ff;
   assign rsp_dirty_bottom = dirty_hi_ff;
   assign rsp_update_count = update_counter_ff;

endmodule

// File: rtl/rpfc_checker.sv
// Port-level checker for the converter, bound to its top level.
`include "rect_pixel_format_converter_unit_macros.svh"

module rpfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_dirty_flag,
   input logic [12:0] rsp_dirty_top,
   input logic [12:0] rsp_dirty_bottom
);

   // No response is pending right after reset.
   `RPFC_ASSERT(a_idle_after_reset, clock, reset, $past(reset) |-> !rsp_valid, "response valid after reset")

   // A stalled response stays valid.
   `RPFC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "stalled response dropped")

   // A taken request shows up as a response once it has passed the request and response registers.
   `RPFC_ASSERT(a_latency, clock, reset, req_valid && !req_stall |-> ##2 rsp_valid, "response missing after request")

   // With the response register empty, requests are never stalled.
   `RPFC_ASSERT_ALWAYS(a_no_false_stall, clock, !rsp_valid |-> !req_stall, "request stalled with empty output")

   // A marked dirty span is never empty.
   `RPFC_ASSERT(a_dirty_span, clock, reset, rsp_valid && rsp_dirty_flag |-> rsp_dirty_bottom > rsp_dirty_top, "empty dirty span")

endmodule

bind rect_pixel_format_converter_unit rpfc_checker u_rpfc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_dirty_flag   (rsp_dirty_flag),
   .rsp_dirty_top    (rsp_dirty_top),
   .rsp_dirty_bottom (rsp_dirty_bottom)
);
